>>> hdl/per_key_order_rate_throttle_core_defines.svh
// Assertion macros used by the checker file.
`ifndef PER_KEY_ORDER_RATE_THROTTLE_CORE_DEFINES_SVH
`define PER_KEY_ORDER_RATE_THROTTLE_CORE_DEFINES_SVH

// Clocked assertion, muted while reset is asserted.
`define PTC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define PTC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> hdl/ptc_pkg.sv
package ptc_pkg;

  localparam int TS_W       = 48;
  localparam int CNT_W      = 32;
  localparam int CFG_W      = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int NUM_WIN    = 6;
  localparam int IN_DATA_W  = 112;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 232;

  // Window counter slots
  localparam int W_CHECKS   = 0;
  localparam int W_ALLOWED  = 1;
  localparam int W_REJECTED = 2;
  localparam int W_INVALID  = 3;
  localparam int W_INTERVAL = 4;
  localparam int W_REVERSE  = 5;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REV_COOLDOWN = 1'd1;

  // Operation codes on the request tuser
  typedef enum logic [1:0] {
    OP_CHECK   = 2'd0,
    OP_ACCEPT  = 2'd1,
    OP_CONSUME = 2'd2
  } op_e;

  // Request class decided by the front end
  typedef enum logic [2:0] {
    K_CHECK,
    K_INVALID,
    K_ACCEPT,
    K_CONSUME,
    K_IGNORE
  } kind_e;

  typedef enum logic [1:0] {
    RSN_NONE     = 2'd0,
    RSN_INVALID  = 2'd1,
    RSN_INTERVAL = 2'd2,
    RSN_REVERSE  = 2'd3
  } reason_e;

  typedef enum logic [1:0] {
    BS_IDLE,
    BS_DIFF,
    BS_EVAL
  } bstate_e;

  typedef struct packed {
    kind_e                   kind;
    logic signed [1:0]       dir;
    logic                    reduce;
    logic signed [TS_W-1:0]  now;
    logic signed [TS_W-1:0]  tick;
  } item_t;

  // One symbol table word
  typedef struct packed {
    logic signed [1:0]       dir;
    logic signed [TS_W-1:0]  tick;
    logic signed [TS_W-1:0]  time_ms;
  } entry_t;

  typedef struct packed {
    logic [CFG_W-1:0] min_interval;
    logic [CFG_W-1:0] rev_cooldown;
  } cfg_t;

  typedef struct packed {
    logic                            allowed;
    reason_e                         reason;
    logic [CNT_W-1:0]                remaining;
    logic [NUM_WIN-1:0][CNT_W-1:0]   win;
  } result_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

endpackage

>>> hdl/ptc_front.sv
module ptc_front #(
  parameter int SYMBOLS = 256,
  localparam int DEPTH  = (SYMBOLS < 256) ? SYMBOLS : 256,
  localparam int IDXW   = $clog2(DEPTH)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [ptc_pkg::IN_USER_W-1:0]   in_user_i,
  input  logic [ptc_pkg::IN_DATA_W-1:0]   in_data_i,
  output logic                            head_valid_o,
  output ptc_pkg::item_t                  head_item_o,
  output logic [IDXW-1:0]                 head_idx_o,
  input  logic                            pop_i
);
  import ptc_pkg::*;

  // symbol_id to table slot, wrapping at SYMBOLS
  function automatic logic [256*IDXW-1:0] build_map();
    logic [256*IDXW-1:0] m;
    m = '0;
    for (int i = 0; i < 256; i++) begin
      m[i*IDXW +: IDXW] = IDXW'(i % SYMBOLS);
    end
    return m;
  endfunction

  localparam logic [256*IDXW-1:0] SYM_MAP = build_map();

  logic [7:0]        sym_id;
  logic              sym_valid;
  logic signed [1:0] dir;
  item_t             item;
  logic [IDXW-1:0]   idx;

  item_t             item_mem_q [2];
  logic [IDXW-1:0]   idx_mem_q  [2];
  logic [1:0]        count_q, count_d;
  logic              wr_ptr_q, rd_ptr_q;
  logic              push;

  assign sym_id    = in_data_i[7:0];
  assign sym_valid = in_data_i[8];
  assign dir       = in_data_i[10:9];
  assign idx       = SYM_MAP[sym_id*IDXW +: IDXW];

  // Classify the request
  always_comb begin
    item.dir    = dir;
    item.reduce = in_data_i[11];
    item.now    = in_data_i[59:12];
    item.tick   = in_data_i[107:60];
    unique case (in_user_i)
      OP_CHECK:   item.kind = (!sym_valid || dir == 2'sd0) ? K_INVALID : K_CHECK;
      OP_ACCEPT:  item.kind = sym_valid ? K_ACCEPT : K_IGNORE;
      OP_CONSUME: item.kind = K_CONSUME;
      default:    item.kind = K_IGNORE;
    endcase
  end

  // Two-entry queue toward the back end
  assign in_ready_o   = (count_q != 2'd2);
  assign push         = in_valid_i && in_ready_o;
  assign head_valid_o = (count_q != 2'd0);
  assign head_item_o  = item_mem_q[rd_ptr_q];
  assign head_idx_o   = idx_mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      item_mem_q[wr_ptr_q] <= item;
      idx_mem_q[wr_ptr_q]  <= idx;
    end
  end

endmodule

>>> hdl/ptc_back.sv
module ptc_back #(
  parameter int SYMBOLS = 256,
  localparam int DEPTH  = (SYMBOLS < 256) ? SYMBOLS : 256,
  localparam int IDXW   = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ptc_pkg::cfg_t     cfg_i,
  input  logic              head_valid_i,
  input  ptc_pkg::item_t    head_item_i,
  input  logic [IDXW-1:0]   head_idx_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ptc_pkg::result_t  out_res_o
);
  import ptc_pkg::*;

  bstate_e             state_q, state_d;
  logic                fire;

  item_t               cur_q;
  logic [IDXW-1:0]     cur_idx_q;
  entry_t              rd_q;
  entry_t              table_mem [DEPTH];
  logic [DEPTH-1:0]    known_q;
  logic                known_r_q;
  logic signed [TS_W:0] el_ms_q, el_tk_q;

  logic [CNT_W-1:0]    win_q [NUM_WIN];
  logic [NUM_WIN-1:0]  bump;
  result_t             res_d, res_q;
  logic                out_valid_q;

  logic signed [1:0]   last_dir;
  logic                now_pos, last_pos, tick_nonneg;
  logic                int_hit, rev_hit;
  logic [CNT_W-1:0]    rem_ms, rem_tk;
  entry_t              wr_entry;

  // Sequencer: next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BS_IDLE: if (head_valid_i) state_d = BS_DIFF;
      BS_DIFF: state_d = BS_EVAL;
      BS_EVAL: if (fire) state_d = BS_IDLE;
      default: state_d = BS_IDLE;
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    pop_o = 1'b0;
    fire  = 1'b0;
    unique case (state_q)
      BS_IDLE: pop_o = head_valid_i;
      BS_EVAL: fire  = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Take the request and read its table word
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q     <= head_item_i;
      cur_idx_q <= head_idx_i;
      rd_q      <= table_mem[head_idx_i];
    end
  end

  // Elapsed time and ticks since the last accept
  always_ff @(posedge clk_i) begin
    if (state_q == BS_DIFF) begin
      el_ms_q   <= {cur_q.now[TS_W-1], cur_q.now} - {rd_q.time_ms[TS_W-1], rd_q.time_ms};
      el_tk_q   <= {cur_q.tick[TS_W-1], cur_q.tick} - {rd_q.tick[TS_W-1], rd_q.tick};
      known_r_q <= known_q[cur_idx_q];
    end
  end

  // Rule evaluation
  always_comb begin
    last_dir    = known_r_q ? rd_q.dir : 2'sd0;
    now_pos     = !cur_q.now[TS_W-1] && (|cur_q.now);
    last_pos    = !rd_q.time_ms[TS_W-1] && (|rd_q.time_ms);
    tick_nonneg = !rd_q.tick[TS_W-1];
    rem_ms      = cfg_i.min_interval - el_ms_q[CNT_W-1:0];
    rem_tk      = cfg_i.rev_cooldown - el_tk_q[CNT_W-1:0];
    int_hit = (cfg_i.min_interval != '0) && now_pos && last_pos && !el_ms_q[TS_W]
              && (el_ms_q[TS_W-1:0] < {{(TS_W-CFG_W){1'b0}}, cfg_i.min_interval});
    rev_hit = (cfg_i.rev_cooldown != '0) && !cur_q.reduce && (last_dir != 2'sd0)
              && (cur_q.dir != last_dir) && tick_nonneg && !el_tk_q[TS_W]
              && (el_tk_q[TS_W-1:0] < {{(TS_W-CFG_W){1'b0}}, cfg_i.rev_cooldown});

    wr_entry.time_ms = cur_q.now;
    wr_entry.tick    = cur_q.tick;
    wr_entry.dir     = (!cur_q.reduce && cur_q.dir != 2'sd0) ? cur_q.dir : last_dir;
  end

  // Result word and counter bumps
  always_comb begin
    res_d.allowed   = 1'b0;
    res_d.reason    = RSN_NONE;
    res_d.remaining = '0;
    res_d.win       = '0;
    bump            = '0;
    unique case (cur_q.kind)
      K_INVALID: begin
        res_d.reason = RSN_INVALID;
        bump[W_CHECKS]   = 1'b1;
        bump[W_REJECTED] = 1'b1;
        bump[W_INVALID]  = 1'b1;
      end
      K_CHECK: begin
        priority if (!known_r_q) begin
          res_d.allowed = 1'b1;
        end else if (int_hit) begin
          res_d.reason     = RSN_INTERVAL;
          res_d.remaining  = rem_ms;
          bump[W_CHECKS]   = 1'b1;
          bump[W_REJECTED] = 1'b1;
          bump[W_INTERVAL] = 1'b1;
        end else if (rev_hit) begin
          res_d.reason     = RSN_REVERSE;
          res_d.remaining  = rem_tk;
          bump[W_CHECKS]   = 1'b1;
          bump[W_REJECTED] = 1'b1;
          bump[W_REVERSE]  = 1'b1;
        end else begin
          res_d.allowed    = 1'b1;
          bump[W_CHECKS]   = 1'b1;
          bump[W_ALLOWED]  = 1'b1;
        end
      end
      K_CONSUME: begin
        for (int k = 0; k < NUM_WIN; k++) begin
          res_d.win[k] = win_q[k];
        end
      end
      default: ;
    endcase
  end

  // Saturating window counters, cleared on consume
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_WIN; k++) begin
        win_q[k] <= '0;
      end
    end else if (fire) begin
      for (int k = 0; k < NUM_WIN; k++) begin
        if (cur_q.kind == K_CONSUME) begin
          win_q[k] <= '0;
        end else if (bump[k]) begin
          win_q[k] <= sat_inc(win_q[k]);
        end
      end
    end
  end

  // Symbol table write on accept
  always_ff @(posedge clk_i) begin
    if (fire && cur_q.kind == K_ACCEPT) begin
      table_mem[cur_idx_q] <= wr_entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      known_q <= '0;
    end else if (fire && cur_q.kind == K_ACCEPT) begin
      known_q[cur_idx_q] <= 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;

endmodule

>>> hdl/per_key_order_rate_throttle_core.sv
// Per-symbol order throttle.
// Requests enter on the s_axis channel: tuser carries the operation (check,
// accept, consume), tdata the symbol, direction, reduce-only flag, time and
// tick. Every request gives exactly one result on the m_axis channel.
// Registers min_interval_ms (index 0) and reverse_cooldown_ticks (index 1)
// are written through cfg_we_i / cfg_idx_i / cfg_wdata_i; the user must write
// them only while idle, and the block itself does not enforce this.
// A front end classifies requests into a two-entry queue; the back end runs
// each request through a three-step sequence: symbol table read, elapsed
// time/tick subtraction, rule evaluation with table and counter update.
// The back end takes a new request only once the previous one has left that
// read-subtract-evaluate sequence on the single-port symbol table.
// Reset clears the registers, the per-symbol known flags and the window
// counters; the table words themselves need no clearing.
// When the receiver stalls, the result holds in the output register, the
// back end waits with the next result, and tready drops once the queue
// is full.
module per_key_order_rate_throttle_core #(
  parameter int SYMBOLS = 256
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration write port
  input  logic                             cfg_we_i,
  input  logic [ptc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [ptc_pkg::CFG_W-1:0]        cfg_wdata_i,
  // request channel
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // tdata: symbol_id[7:0], symbol_valid[8], direction[10:9], reduce[11],
  //        now_ms[59:12], tick[107:60], zero fill[111:108]
  input  logic [ptc_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // tuser: op[1:0]
  input  logic [ptc_pkg::IN_USER_W-1:0]    s_axis_tuser,
  // result channel
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // tdata: allowed[0], reason_code[2:1], remaining[34:3], win_checks[66:35],
  //        win_allowed[98:67], win_rejected[130:99], win_invalid[162:131],
  //        win_interval[194:163], win_reverse[226:195], zero fill[231:227]
  output logic [ptc_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
  import ptc_pkg::*;

  localparam int DEPTH = (SYMBOLS < 256) ? SYMBOLS : 256;
  localparam int IDXW  = $clog2(DEPTH);

  logic              min_we, cd_we;
  logic [CFG_W-1:0]  min_q, cd_q;
  cfg_t              cfg;
  logic              head_valid, pop;
  item_t             head_item;
  logic [IDXW-1:0]   head_idx;
  result_t           res;

  // Configuration registers
  always_comb begin
    min_we = 1'b0;
    cd_we  = 1'b0;
    unique case (cfg_idx_i)
      CFG_MIN_INTERVAL: min_we = cfg_we_i;
      CFG_REV_COOLDOWN: cd_we  = cfg_we_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= '0;
      cd_q  <= '0;
    end else begin
      if (min_we) min_q <= cfg_wdata_i;
      if (cd_we)  cd_q  <= cfg_wdata_i;
    end
  end

  assign cfg.min_interval = min_q;
  assign cfg.rev_cooldown = cd_q;

  ptc_front #(.SYMBOLS(SYMBOLS)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_user_i    (s_axis_tuser),
    .in_data_i    (s_axis_tdata),
    .head_valid_o (head_valid),
    .head_item_o  (head_item),
    .head_idx_o   (head_idx),
    .pop_i        (pop)
  );

  ptc_back #(.SYMBOLS(SYMBOLS)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .head_valid_i (head_valid),
    .head_item_i  (head_item),
    .head_idx_i   (head_idx),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_res_o    (res)
  );

  // Pack the result, first field lowest
  assign m_axis_tdata = {5'b0,
                         res.win[W_REVERSE], res.win[W_INTERVAL], res.win[W_INVALID],
                         res.win[W_REJECTED], res.win[W_ALLOWED], res.win[W_CHECKS],
                         res.remaining, res.reason, res.allowed};

endmodule

>>> hdl/ptc_checker.sv
`include "per_key_order_rate_throttle_core_defines.svh"

module ptc_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [ptc_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
  import ptc_pkg::*;

  logic       allowed;
  logic [1:0] reason;
  logic       rem_zero;

  assign allowed  = m_axis_tdata[0];
  assign reason   = m_axis_tdata[2:1];
  assign rem_zero = (m_axis_tdata[34:3] == '0);

  // a stalled result stays put
  `PTC_ASSERT(a_stall_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

  // an allowed check carries no reason and no wait
  `PTC_ASSERT(a_allowed_clean, m_axis_tvalid && allowed |-> reason == RSN_NONE && rem_zero, "allowed result with reason or remaining")

  // a rule rejection always has a nonzero wait
  `PTC_ASSERT(a_rule_wait, m_axis_tvalid && (reason == RSN_INTERVAL || reason == RSN_REVERSE) |-> !allowed && !rem_zero, "rule rejection without remaining")

  // invalid intents report no wait
  `PTC_ASSERT(a_invalid_nowait, m_axis_tvalid && reason == RSN_INVALID |-> !allowed && rem_zero, "invalid rejection with remaining")

  // a reset edge leaves no result showing on the next cycle
  `PTC_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> !m_axis_tvalid, "result valid during reset")

endmodule

bind per_key_order_rate_throttle_core ptc_checker u_ptc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
